// File: design/ifdq_pkg.sv
// ----------------------------------------------------------------------------
// ifdq_pkg
// Shared types, sizes and helpers of the indexed fifo deque.
// ----------------------------------------------------------------------------
package ifdq_pkg;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned DATA_WIDTH = 32;

  localparam int unsigned AddrW  = $clog2(DEPTH);
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned SumW   = AddrW + 1;

  // port widths fixed by the transaction format
  localparam int unsigned ReqTypeW = 2;
  localparam int unsigned PushW    = 32;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned RdDataW  = 32;
  localparam int unsigned ErrW     = 2;
  localparam int unsigned CountW   = 9;

  localparam int unsigned CmpW = (CntW > IndexW) ? CntW : IndexW;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_APPEND = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } ifdq_req_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK    = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_FULL  = 2'd3
  } ifdq_err_e;

  // outcome of one request, known at acceptance
  typedef struct packed {
    ifdq_err_e           err;
    logic [CntW-1:0]     count;
    logic                rd_ok;
  } ifdq_stat_t;

  // ring position of an offset from the front, offset below DEPTH
  function automatic logic [AddrW-1:0] ring_add(input logic [AddrW-1:0] front,
                                                input logic [AddrW-1:0] offset);
    logic [SumW-1:0] sum;
    sum = SumW'(front) + SumW'(offset);
    if (sum >= SumW'(DEPTH)) begin
      sum = sum - SumW'(DEPTH);
    end
    return sum[AddrW-1:0];
  endfunction

endpackage

// File: design/ifdq_if.sv
// ----------------------------------------------------------------------------
// ifdq request and response channels
// Valid/ready channels carrying one request or one response per transaction.
// ----------------------------------------------------------------------------
interface ifdq_req_if
  import ifdq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [PushW-1:0]    push_value;
  logic [IndexW-1:0]   read_index;

  modport source (output valid, output req_type, output push_value, output read_index,
                  input ready);
  modport sink   (input valid, input req_type, input push_value, input read_index,
                  output ready);
endinterface

interface ifdq_rsp_if
  import ifdq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [RdDataW-1:0] read_data;
  logic [ErrW-1:0]    error_code;
  logic [CountW-1:0]  entry_count;
  logic               empty_flag;

  modport source (output valid, output read_data, output error_code, output entry_count,
                  output empty_flag, input ready);
  modport sink   (input valid, input read_data, input error_code, input entry_count,
                  input empty_flag, output ready);
endinterface

// File: design/ifdq_ram.sv
// ----------------------------------------------------------------------------
// ifdq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ifdq_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ifdq_ctrl.sv
// ----------------------------------------------------------------------------
// ifdq_ctrl
// Front pointer and count of the ring; decodes a request into a memory
// access and its outcome.
// ----------------------------------------------------------------------------
module ifdq_ctrl
  import ifdq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  ifdq_req_e             req_type_i,
  input  logic [PushW-1:0]      push_value_i,
  input  logic [IndexW-1:0]     read_index_i,
  output logic                  mem_we_o,
  output logic [AddrW-1:0]      mem_waddr_o,
  output logic [DATA_WIDTH-1:0] mem_wdata_o,
  output logic                  mem_re_o,
  output logic [AddrW-1:0]      mem_raddr_o,
  output ifdq_stat_t            stat_o
);

  logic [AddrW-1:0] front_q, front_d;
  logic [CntW-1:0]  count_q, count_d;
  ifdq_stat_t       stat;
  logic             do_write;
  logic             do_read;

  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    do_write   = 1'b0;
    do_read    = 1'b0;
    stat.err   = ERR_OK;
    stat.rd_ok = 1'b0;
    unique case (req_type_i)
      REQ_APPEND: begin
        if (count_q >= CntW'(DEPTH)) begin
          stat.err = ERR_FULL;
        end else begin
          do_write = 1'b1;
          count_d  = count_q + CntW'(1);
        end
      end
      REQ_REMOVE: begin
        if (count_q == '0) begin
          stat.err = ERR_EMPTY;
        end else begin
          front_d = ring_add(front_q, AddrW'(1));
          count_d = count_q - CntW'(1);
        end
      end
      REQ_READ: begin
        if (CmpW'(read_index_i) >= CmpW'(count_q)) begin
          stat.err = ERR_RANGE;
        end else begin
          do_read    = 1'b1;
          stat.rd_ok = 1'b1;
        end
      end
      REQ_CLEAR: begin
        front_d = '0;
        count_d = '0;
      end
      default: begin
        stat.err = ERR_OK;
      end
    endcase
    stat.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // the back slot lies count entries past the front; count is below DEPTH here
  assign mem_we_o    = accept_i & do_write;
  assign mem_waddr_o = ring_add(front_q, count_q[AddrW-1:0]);
  assign mem_wdata_o = DATA_WIDTH'(push_value_i);
  assign mem_re_o    = accept_i & do_read;
  assign mem_raddr_o = ring_add(front_q, read_index_i[AddrW-1:0]);
  assign stat_o      = stat;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && req_type_i == REQ_CLEAR |=> count_q == '0 && front_q == '0)
    else $error("clear did not empty the ring");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |=> count_q == $past(count_q) + CntW'(1))
    else $error("append did not grow the count");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("write and read in the same transaction");

endmodule

// File: design/indexed_fifo_deque.sv
// ----------------------------------------------------------------------------
// indexed_fifo_deque
// Fifo of fixed-width elements with append, remove, indexed read and clear.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (valid/ready); each gives exactly one response on
// rsp_o carrying the element read, an error code, the entry count after the
// request and an empty flag. A failed request leaves the queue unchanged.
// Elements live in a ring held in a synchronous RAM with a front pointer and
// a count kept in flops; pointer and count update in the cycle of acceptance.
// A request passes through the RAM read stage and then the response register
// before its response is valid. Throughput is one request per cycle while the
// receiver takes responses; no forwarding is needed since a read only reaches
// entries written in earlier transactions. When the receiver stalls, the
// response register holds and one further request may sit in the RAM read
// stage, after which ready drops until the response is taken. Reset clears
// the pointer, the count and all valid flags at once; the RAM contents are
// left as they are, so the queue is usable in the first cycle after reset.
// ----------------------------------------------------------------------------
module indexed_fifo_deque
  import ifdq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ifdq_req_if.sink   req_i,
  ifdq_rsp_if.source rsp_o
);

  logic                  accept;
  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AddrW-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  ifdq_stat_t            stat;

  logic       s1_valid_q, s1_valid_d;
  ifdq_stat_t s1_stat_q;
  logic       s1_adv;

  logic               out_valid_q, out_valid_d;
  logic [RdDataW-1:0] out_data_q;
  logic [ErrW-1:0]    out_err_q;
  logic [CountW-1:0]  out_count_q;
  logic               out_empty_q;

  assign s1_adv      = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign accept      = req_i.valid && req_i.ready;

  ifdq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (ifdq_req_e'(req_i.req_type)),
    .push_value_i (req_i.push_value),
    .read_index_i (req_i.read_index),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .stat_o       (stat)
  );

  ifdq_ram #(
    .Depth (DEPTH),
    .Width (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ram read stage
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_stat_q <= stat;
    end
  end

  // response register
  assign out_valid_d = s1_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_data_q  <= s1_stat_q.rd_ok ? RdDataW'(mem_rdata) : '0;
      out_err_q   <= s1_stat_q.err;
      out_count_q <= CountW'(s1_stat_q.count);
      out_empty_q <= (s1_stat_q.count == '0);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_data   = out_data_q;
  assign rsp_o.error_code  = out_err_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.empty_flag  = out_empty_q;

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("read stage dropped a transaction");

  a_ready_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken with both stages full");

  a_ok_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_stat_q.rd_ok |-> s1_stat_q.err == ERR_OK && s1_stat_q.count != '0)
    else $error("read issued on an error or empty queue");

endmodule
